### rtl/fafl_pkg.sv
// ----------------------------------------------------------------------------
// fafl_pkg
// Shared types and constants for the follower axis feedforward loop.
// ----------------------------------------------------------------------------
package fafl_pkg;

  // Action code carried by each input word
  typedef enum logic [1:0] {
    ACT_TICK      = 2'd0,
    ACT_ENGAGE    = 2'd1,
    ACT_DISENGAGE = 2'd2,
    ACT_RESET_REF = 2'd3
  } action_t;

  // Command kind carried by each result word
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_DRIVE = 2'd1,
    KIND_BRAKE = 2'd2
  } kind_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_POS_MUL,
    ST_ERROR,
    ST_CHECK,
    ST_PC_MUL,
    ST_FF1_MUL,
    ST_FF2_MUL,
    ST_SATURATE,
    ST_EMIT
  } state_t;

  // Serial multiplier geometry: radix-4 Booth over the 16 bit gain
  localparam int MUL_A_W   = 38;
  localparam int MUL_B_W   = 16;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W / 2;
  localparam int FRAC_W    = 12;

  // Configuration register map
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_FOLLOW_RATIO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDFORWARD_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TOLERANCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_LIMIT   = 3'd4;

  // Register reset values
  localparam logic signed [15:0] RST_FOLLOW_RATIO     = -16'sd819;
  localparam logic signed [15:0] RST_POSITION_GAIN    = 16'sd4915;
  localparam logic signed [15:0] RST_FEEDFORWARD_GAIN = 16'sd4096;
  localparam logic [15:0]        RST_SETTLE_TOLERANCE = 16'd32;
  localparam logic [14:0]        RST_VELOCITY_LIMIT   = 15'd3200;

  // Multiplier request and response bundles
  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

endpackage

### rtl/fafl_in_if.sv
// ----------------------------------------------------------------------------
// fafl_in_if
// Input channel: one word per leader/follower sample and action.
// ----------------------------------------------------------------------------
interface fafl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [31:0] leader_position;
  logic signed [15:0] leader_velocity;
  logic signed [31:0] follower_position;
  logic               follower_stall_lock;

  modport source (
    output valid, action, leader_position, leader_velocity,
           follower_position, follower_stall_lock,
    input  ready
  );

  modport sink (
    input  valid, action, leader_position, leader_velocity,
           follower_position, follower_stall_lock,
    output ready
  );
endinterface

### rtl/fafl_out_if.sv
// ----------------------------------------------------------------------------
// fafl_out_if
// Result channel: one command word per input word.
// ----------------------------------------------------------------------------
interface fafl_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command_kind;
  logic signed [15:0] velocity_command;

  modport source (
    output valid, command_kind, velocity_command,
    input  ready
  );

  modport sink (
    input  valid, command_kind, velocity_command,
    output ready
  );
endinterface

### rtl/fafl_mul.sv
// ----------------------------------------------------------------------------
// fafl_mul
// Signed serial multiplier, radix-4 Booth, one gain digit per cycle, MSB first.
// ----------------------------------------------------------------------------
module fafl_mul (
  input  logic                clk,
  input  logic                rst_n,
  input  fafl_pkg::mul_req_t  req,
  output fafl_pkg::mul_rsp_t  rsp
);
  import fafl_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic signed [MUL_A_W-1:0] a_r, a_nxt;
  logic [MUL_B_W:0]          bsh_r, bsh_nxt;
  logic signed [MUL_P_W-1:0] acc_r, acc_nxt;
  logic signed [MUL_P_W-1:0] a_ext;
  logic signed [MUL_P_W-1:0] term;

  always_comb begin
    a_ext = $signed({{(MUL_P_W-MUL_A_W){a_r[MUL_A_W-1]}}, a_r});
    // Booth digit from the top three bits of the gain shifter
    case (bsh_r[MUL_B_W -: 3])
      3'b001, 3'b010: term = a_ext;
      3'b011:         term = a_ext <<< 1;
      3'b100:         term = -(a_ext <<< 1);
      3'b101, 3'b110: term = -a_ext;
      default:        term = '0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    bsh_nxt  = bsh_r;
    acc_nxt  = acc_r;
    if (req.start && !busy_r) begin
      a_nxt    = $signed(req.a);
      bsh_nxt  = {req.b, 1'b0};
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = (acc_r <<< 2) + term;
      bsh_nxt = {bsh_r[MUL_B_W-2:0], 2'b00};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MUL_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    bsh_r <= bsh_nxt;
    acc_r <= acc_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

endmodule

### rtl/follower_axis_feedforward_loop.sv
// ----------------------------------------------------------------------------
// follower_axis_feedforward_loop
// Follower axis tracking: offset capture, P correction plus velocity feedforward.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake           payload
//  in_chan   in    valid/ready         action, leader/follower pos, leader vel, lock
//  out_chan  out   valid/ready         command_kind, velocity_command
//  cfg_*     in    APB, pready tied 1  five registers at byte address 4*i
//
//  One word in process at a time; a new word is taken only in the idle state.
//  Between acceptances, a driving tick runs four Booth passes plus sequencing;
//  a braking tick and an offset-capturing engage run one, other words none.
//  The result sits in an output register, so the next word can be taken while
//  the previous result waits for out_chan.ready.
//  Reset (rst_n low, synchronous) clears the follow flags, offset reference
//  and registers to their defaults.
//
module follower_axis_feedforward_loop (
  input  logic                            clk,
  input  logic                            rst_n,
  fafl_in_if.sink                         in_chan,
  fafl_out_if.source                      out_chan,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [fafl_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import fafl_pkg::*;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] ratio_r;
  logic signed [15:0] pgain_r;
  logic signed [15:0] ffgain_r;
  logic [15:0]        tol_r;
  logic [14:0]        vlim_r;
  logic               cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_r  <= RST_FOLLOW_RATIO;
      pgain_r  <= RST_POSITION_GAIN;
      ffgain_r <= RST_FEEDFORWARD_GAIN;
      tol_r    <= RST_SETTLE_TOLERANCE;
      vlim_r   <= RST_VELOCITY_LIMIT;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FOLLOW_RATIO:     ratio_r  <= cfg_pwdata[15:0];
        REG_POSITION_GAIN:    pgain_r  <= cfg_pwdata[15:0];
        REG_FEEDFORWARD_GAIN: ffgain_r <= cfg_pwdata[15:0];
        REG_SETTLE_TOLERANCE: tol_r    <= cfg_pwdata[15:0];
        REG_VELOCITY_LIMIT:   vlim_r   <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FOLLOW_RATIO:     cfg_prdata = {16'd0, ratio_r};
      REG_POSITION_GAIN:    cfg_prdata = {16'd0, pgain_r};
      REG_FEEDFORWARD_GAIN: cfg_prdata = {16'd0, ffgain_r};
      REG_SETTLE_TOLERANCE: cfg_prdata = {16'd0, tol_r};
      REG_VELOCITY_LIMIT:   cfg_prdata = {17'd0, vlim_r};
      default:              cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic               following_r, following_nxt;
  logic               settling_r, settling_nxt;
  logic               held_r, held_nxt;
  logic signed [31:0] offset_r, offset_nxt;

  // captured input word
  action_t            act_r, act_nxt;
  logic signed [31:0] lpos_r, lpos_nxt;
  logic signed [15:0] lvel_r, lvel_nxt;
  logic signed [31:0] fpos_r, fpos_nxt;
  logic               lock_r, lock_nxt;

  // intermediates
  logic signed [35:0] p_r, p_nxt;       // floor(lpos * ratio / 4096)
  logic signed [37:0] err_r, err_nxt;   // target - follower position
  logic signed [41:0] pc_r, pc_nxt;     // proportional term
  logic signed [42:0] cmd_r, cmd_nxt;   // unsaturated command

  // pending result and output register
  kind_t              kind_r, kind_nxt;
  logic [15:0]        vel_r, vel_nxt;
  logic               out_valid_r, out_valid_nxt;
  kind_t              out_kind_r, out_kind_nxt;
  logic [15:0]        out_vel_r, out_vel_nxt;

  mul_req_t           mreq;
  mul_rsp_t           mrsp;

  logic signed [37:0] tol_ext;
  logic signed [42:0] lim_ext;

  fafl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign tol_ext = $signed({22'd0, tol_r});
  assign lim_ext = $signed({28'd0, vlim_r});

  assign in_chan.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    following_nxt = following_r;
    settling_nxt  = settling_r;
    held_nxt      = held_r;
    offset_nxt    = offset_r;
    act_nxt       = act_r;
    lpos_nxt      = lpos_r;
    lvel_nxt      = lvel_r;
    fpos_nxt      = fpos_r;
    lock_nxt      = lock_r;
    p_nxt         = p_r;
    err_nxt       = err_r;
    pc_nxt        = pc_r;
    cmd_nxt       = cmd_r;
    kind_nxt      = kind_r;
    vel_nxt       = vel_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_kind_nxt  = out_kind_r;
    out_vel_nxt   = out_vel_r;
    mreq.start    = 1'b0;
    mreq.a        = '0;
    mreq.b        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          act_nxt   = action_t'(in_chan.action);
          lpos_nxt  = in_chan.leader_position;
          lvel_nxt  = in_chan.leader_velocity;
          fpos_nxt  = in_chan.follower_position;
          lock_nxt  = in_chan.follower_stall_lock;
          state_nxt = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        kind_nxt = KIND_NONE;
        vel_nxt  = '0;
        case (act_r)
          ACT_ENGAGE: begin
            if (lock_r) begin
              state_nxt = ST_EMIT;
            end else if (held_r) begin
              // reference kept, offset stays
              following_nxt = 1'b1;
              settling_nxt  = 1'b0;
              state_nxt     = ST_EMIT;
            end else begin
              mreq.start = 1'b1;
              mreq.a     = {{6{lpos_r[31]}}, lpos_r};
              mreq.b     = ratio_r;
              state_nxt  = ST_POS_MUL;
            end
          end
          ACT_DISENGAGE: begin
            if (following_r) begin
              following_nxt = 1'b0;
              settling_nxt  = 1'b1;
            end
            state_nxt = ST_EMIT;
          end
          ACT_RESET_REF: begin
            following_nxt = 1'b0;
            settling_nxt  = 1'b0;
            held_nxt      = 1'b0;
            state_nxt     = ST_EMIT;
          end
          ACT_TICK: begin
            if ((following_r || settling_r) && held_r && !lock_r) begin
              mreq.start = 1'b1;
              mreq.a     = {{6{lpos_r[31]}}, lpos_r};
              mreq.b     = ratio_r;
              state_nxt  = ST_POS_MUL;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
          default: state_nxt = ST_EMIT;
        endcase
      end

      ST_POS_MUL: begin
        if (mrsp.done) begin
          p_nxt     = mrsp.prod[47:FRAC_W];
          state_nxt = ST_ERROR;
        end
      end

      ST_ERROR: begin
        if (act_r == ACT_ENGAGE) begin
          // offset wraps to 32 bits
          offset_nxt    = fpos_r - p_r[31:0];
          held_nxt      = 1'b1;
          following_nxt = 1'b1;
          settling_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end else begin
          err_nxt = $signed({{6{offset_r[31]}}, offset_r})
                  + $signed({{2{p_r[35]}}, p_r})
                  - $signed({{6{fpos_r[31]}}, fpos_r});
          state_nxt = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (!following_r && (err_r < tol_ext) && (err_r > -tol_ext)) begin
          kind_nxt     = KIND_BRAKE;
          settling_nxt = 1'b0;
          state_nxt    = ST_EMIT;
        end else begin
          mreq.start = 1'b1;
          mreq.a     = err_r;
          mreq.b     = pgain_r;
          state_nxt  = ST_PC_MUL;
        end
      end

      ST_PC_MUL: begin
        if (mrsp.done) begin
          pc_nxt     = mrsp.prod[MUL_P_W-1:FRAC_W];
          mreq.start = 1'b1;
          mreq.a     = {{22{lvel_r[15]}}, lvel_r};
          mreq.b     = ratio_r;
          state_nxt  = ST_FF1_MUL;
        end
      end

      ST_FF1_MUL: begin
        if (mrsp.done) begin
          // floor(lvel * ratio / 4096) fits 20 bits
          mreq.start = 1'b1;
          mreq.a     = {{18{mrsp.prod[31]}}, mrsp.prod[31:FRAC_W]};
          mreq.b     = ffgain_r;
          state_nxt  = ST_FF2_MUL;
        end
      end

      ST_FF2_MUL: begin
        if (mrsp.done) begin
          cmd_nxt = $signed({pc_r[41], pc_r})
                  + $signed({{19{mrsp.prod[35]}}, mrsp.prod[35:FRAC_W]});
          state_nxt = ST_SATURATE;
        end
      end

      ST_SATURATE: begin
        kind_nxt = KIND_DRIVE;
        if (cmd_r > lim_ext) begin
          vel_nxt = {1'b0, vlim_r};
        end else if (cmd_r < -lim_ext) begin
          vel_nxt = -{1'b0, vlim_r};
        end else begin
          vel_nxt = cmd_r[15:0];
        end
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        // hand off to the output register once it is free
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_vel_nxt   = vel_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      following_r <= 1'b0;
      settling_r  <= 1'b0;
      held_r      <= 1'b0;
      offset_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      following_r <= following_nxt;
      settling_r  <= settling_nxt;
      held_r      <= held_nxt;
      offset_r    <= offset_nxt;
      out_valid_r <= out_valid_nxt;
    end
    act_r      <= act_nxt;
    lpos_r     <= lpos_nxt;
    lvel_r     <= lvel_nxt;
    fpos_r     <= fpos_nxt;
    lock_r     <= lock_nxt;
    p_r        <= p_nxt;
    err_r      <= err_nxt;
    pc_r       <= pc_nxt;
    cmd_r      <= cmd_nxt;
    kind_r     <= kind_nxt;
    vel_r      <= vel_nxt;
    out_kind_r <= out_kind_nxt;
    out_vel_r  <= out_vel_nxt;
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.command_kind     = out_kind_r;
  assign out_chan.velocity_command = out_vel_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(following_r && settling_r))
    else $error("following and settling both set");

  a_zero_unless_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r != KIND_DRIVE)) |-> (out_vel_r == '0))
    else $error("nonzero velocity on a non-drive word");

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> ((state_r == ST_POS_MUL) || (state_r == ST_PC_MUL) ||
                   (state_r == ST_FF1_MUL) || (state_r == ST_FF2_MUL)))
    else $error("multiplier finished outside a wait state");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> (state_r == ST_DISPATCH))
    else $error("accepted word not dispatched");

endmodule
